/* hdl/integer_set_table_assert.svh */
// assertion macros for the integer set table
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define IST_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

`define IST_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`else

`define IST_ASSERT(name, prop, msg)

`define IST_NEVER(name, cond, msg)

`endif

`endif

/* hdl/ist_pkg.sv */
// shared constants and types for the integer set table
`default_nettype none

package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 2;
	localparam int COUNT_W  = 5;
	localparam int OUT_TDATA_W = ((2 + COUNT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 2 - COUNT_W;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ADD    = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN
	} ist_state_t;

	typedef struct packed {
		logic               found;
		logic               dropped;
		logic [COUNT_W-1:0] count;
	} ist_result_t;

endpackage

`default_nettype wire

/* hdl/ist_ram.sv */
// simple dual-port synchronous ram, registered read
`default_nettype none

module ist_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/ist_ctrl.sv */
// command sequencer: scans, appends and shifts entries through the ram
`default_nettype none

`include "integer_set_table_assert.svh"

module ist_ctrl
	import ist_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cmd_t               in_cmd,
	input  wire logic [VALUE_W-1:0] in_value,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output ist_result_t             res,
	output logic                    mem_we,
	output logic [IDX_W-1:0]        mem_waddr,
	output logic [VALUE_W-1:0]      mem_wdata,
	output logic [IDX_W-1:0]        mem_raddr,
	input  wire logic [VALUE_W-1:0] mem_rdata
);

	ist_state_t         state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               found_q, found_d;
	logic               dropped_q, dropped_d;
	cmd_t               cmd_q, cmd_d;
	logic [VALUE_W-1:0] value_q, value_d;
	logic               hit;
	logic               last;
	logic               shift_done;

	assign hit        = (count_q != '0) && (mem_rdata == value_q);
	assign last       = (count_q == '0) || ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign shift_done = (CNT_W'(idx_q) + CNT_W'(2)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
			cmd_q     <= CMD_ADD;
		end else begin
			count_q   <= count_d;
			idx_q     <= idx_d;
			found_q   <= found_d;
			dropped_q <= dropped_d;
			cmd_q     <= cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		found_d   = found_q;
		dropped_d = dropped_q;
		cmd_d     = cmd_q;
		value_d   = value_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_d     = in_cmd;
					value_d   = in_value;
					idx_d     = '0;
					found_d   = 1'b0;
					dropped_d = 1'b0;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_raddr = idx_q + IDX_W'(1);
				if (hit) begin
					found_d = 1'b1;
					if (cmd_q == CMD_REMOVE) begin
						if (last) begin
							count_d = count_q - CNT_W'(1);
							state_d = ST_FIN;
						end else begin
							state_d = ST_SHIFT;
						end
					end else begin
						state_d = ST_FIN;
					end
				end else if (last) begin
					if (cmd_q == CMD_ADD) begin
						if (count_q < CNT_W'(CAPACITY)) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[IDX_W-1:0];
							mem_wdata = value_q;
							count_d   = count_q + CNT_W'(1);
						end else begin
							dropped_d = 1'b1;
						end
					end
					state_d = ST_FIN;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_SHIFT: begin
				// move the next entry down one place
				mem_raddr = idx_q + IDX_W'(2);
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				if (shift_done) begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_FIN;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.found   = found_q;
	assign res.dropped = dropped_q;
	assign res.count   = COUNT_W'(count_q);

	`IST_NEVER(a_count_cap, count_q > CNT_W'(CAPACITY), "entry count above capacity")
	`IST_ASSERT(a_we_state, mem_we |-> (state_q == ST_SCAN || state_q == ST_SHIFT), "ram write outside scan or shift")
	`IST_ASSERT(a_drop_full, (res_valid && dropped_q) |-> (count_q == CNT_W'(CAPACITY) && !found_q), "drop while not full or value found")
	`IST_ASSERT(a_count_step, (count_q != $past(count_q)) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_SHIFT), "count changed outside a command")

endmodule

`default_nettype wire

/* hdl/integer_set_table.sv */
// One command is held at a time: a new one is accepted only after the result of the last
// has been passed to the output register, so a stalled output also holds off the next command.
// The time a command takes is set by the scan, one ram entry per cycle through the single read port.
// A remove shifts later entries through the same port, the match search plus shift
// still touching each held entry once. Reset clears count and control at once;
// the ram is not cleared and needs no clearing pass.
`default_nettype none

module integer_set_table
	import ist_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic signed [VALUE_W-1:0] s_axis_tdata, // value
	input  wire logic [CMD_W-1:0]       s_axis_tuser, // cmd
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata  // found, dropped, count, zero pad
);

	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [VALUE_W-1:0]     mem_wdata;
	logic [IDX_W-1:0]       mem_raddr;
	logic [VALUE_W-1:0]     mem_rdata;
	logic                   res_valid;
	logic                   res_ready;
	ist_result_t            res;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	ist_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_W),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_value (VALUE_W'(s_axis_tdata)),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// output register, refilled as the held transaction leaves
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= {{OUT_PAD_W{1'b0}}, res.count, res.dropped, res.found};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
